// ----- rtl/core/erse_pkg.sv -----
// ----------------------------------------------------------------------------
// erse_pkg
// Shared sizes, codes and control structs of the event ring subscription core.
// ----------------------------------------------------------------------------
package erse_pkg;

    localparam int RING_DEPTH = 256;   // power of two
    localparam int SUB_SLOTS  = 64;
    localparam int ID_BITS    = 32;

    localparam int FIELD_W = 32;
    localparam int PAY_W   = 64;
    localparam int SEQ_W   = 32;
    localparam int TAG_W   = (ID_BITS < FIELD_W) ? ID_BITS : FIELD_W;
    localparam int RING_AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SUB_AW  = (SUB_SLOTS > 1) ? $clog2(SUB_SLOTS) : 1;
    localparam int CNT_W   = $clog2(SUB_SLOTS + 1);
    localparam int RING_W  = TAG_W + PAY_W + SEQ_W;
    localparam int SUB_W   = TAG_W + TAG_W + SEQ_W;

    typedef enum logic [1:0] {
        OP_POST  = 2'd0,
        OP_SUB   = 2'd1,
        OP_UNSUB = 2'd2,
        OP_POLL  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EXISTS = 2'd1,
        ST_FULL   = 2'd2,
        ST_NONE   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        RES_POST,
        RES_OK,
        RES_EXISTS,
        RES_FULL,
        RES_NONE,
        RES_HIT
    } res_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_WALK_RD,
        S_WALK_CHK,
        S_CUR_WB,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic     accept;
        logic     post;
        logic     scan_rd;
        logic     scan_chk;
        logic     sub_write;
        logic     unsub_clear;
        logic     poll_load;
        logic     idx_inc;
        logic     walk_rd;
        logic     cur_wb;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } erse_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    scan_end;
        logic    pair_match;
        logic    cell_hit;
        logic    free_found;
        logic    table_full;
        logic    walk_end;
        logic    surf_hit;
        logic    out_ready;
    } erse_stat_t;

endpackage

// ----- rtl/core/erse_ram.sv -----
// ----------------------------------------------------------------------------
// erse_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module erse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/erse_dp.sv -----
// ----------------------------------------------------------------------------
// erse_dp
// Datapath: event ring, subscription table, counters, result and output regs.
// ----------------------------------------------------------------------------
module erse_dp
    import erse_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  erse_cmd_t           cmd,
    output erse_stat_t          stat,
    input  logic [1:0]          opcode,
    input  logic [FIELD_W-1:0]  surface_id,
    input  logic [FIELD_W-1:0]  cell_id,
    input  logic [PAY_W-1:0]    payload,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic                event_found,
    output logic [SEQ_W-1:0]    event_seq,
    output logic [FIELD_W-1:0]  event_surface,
    output logic [PAY_W-1:0]    event_payload
);

    // captured request
    opcode_t            op_reg;
    logic [TAG_W-1:0]   surf_reg;
    logic [TAG_W-1:0]   cell_reg;
    logic [PAY_W-1:0]   pay_reg;

    // state
    logic [SEQ_W-1:0]   wc_reg;
    logic [CNT_W-1:0]   used_reg;
    logic [SUB_SLOTS-1:0]  active_reg;
    logic [RING_DEPTH-1:0] rvalid_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [SUB_AW-1:0]  free_idx_reg;
    logic               free_found_reg;
    logic [SEQ_W-1:0]   cur_reg;
    logic               rv_q_reg;

    // result and output
    status_t            res_status_reg;
    logic               res_found_reg;
    logic [SEQ_W-1:0]   res_seq_reg;
    logic [FIELD_W-1:0] res_surf_reg;
    logic [PAY_W-1:0]   res_pay_reg;
    logic               out_valid_reg;
    status_t            out_status_reg;
    logic               out_found_reg;
    logic [SEQ_W-1:0]   out_seq_reg;
    logic [FIELD_W-1:0] out_surf_reg;
    logic [PAY_W-1:0]   out_pay_reg;

    logic [SUB_AW-1:0]  idx;
    logic [SUB_AW-1:0]  pick;
    logic               sub_we;
    logic [SUB_AW-1:0]  sub_waddr;
    logic [SUB_W-1:0]   sub_wdata;
    logic [SUB_W-1:0]   sub_rdata;
    logic [TAG_W-1:0]   s_surf;
    logic [TAG_W-1:0]   s_cell;
    logic [SEQ_W-1:0]   s_cur;
    logic [RING_W-1:0]  ring_rdata;
    logic [TAG_W-1:0]   r_surf;
    logic [PAY_W-1:0]   r_pay;
    logic [SEQ_W-1:0]   r_seq;
    logic [SEQ_W-1:0]   lag;
    logic [SEQ_W-1:0]   cur_start;

    assign idx  = idx_reg[SUB_AW-1:0];
    assign pick = free_found_reg ? free_idx_reg : used_reg[SUB_AW-1:0];

    assign s_surf = sub_rdata[SUB_W-1 -: TAG_W];
    assign s_cell = sub_rdata[SEQ_W + TAG_W - 1 -: TAG_W];
    assign s_cur  = sub_rdata[SEQ_W-1:0];

    // unwritten ring entries read as zero
    assign r_surf = rv_q_reg ? ring_rdata[RING_W-1 -: TAG_W] : '0;
    assign r_pay  = rv_q_reg ? ring_rdata[SEQ_W + PAY_W - 1 -: PAY_W] : '0;
    assign r_seq  = rv_q_reg ? ring_rdata[SEQ_W-1:0] : '0;

    assign lag       = wc_reg - s_cur;
    assign cur_start = (lag > SEQ_W'(RING_DEPTH)) ? (wc_reg - SEQ_W'(RING_DEPTH)) : s_cur;

    assign sub_we    = cmd.sub_write || cmd.cur_wb;
    assign sub_waddr = cmd.sub_write ? pick : idx;
    assign sub_wdata = cmd.sub_write ? {surf_reg, cell_reg, wc_reg} : {s_surf, s_cell, cur_reg};

    erse_ram #(
        .WIDTH (SUB_W),
        .DEPTH (SUB_SLOTS)
    ) u_sub_ram (
        .clk   (clk),
        .we    (sub_we),
        .waddr (sub_waddr),
        .wdata (sub_wdata),
        .re    (cmd.scan_rd),
        .raddr (idx),
        .rdata (sub_rdata)
    );

    erse_ram #(
        .WIDTH (RING_W),
        .DEPTH (RING_DEPTH)
    ) u_ring_ram (
        .clk   (clk),
        .we    (cmd.post),
        .waddr (wc_reg[RING_AW-1:0]),
        .wdata ({surf_reg, pay_reg, wc_reg}),
        .re    (cmd.walk_rd),
        .raddr (cur_reg[RING_AW-1:0]),
        .rdata (ring_rdata)
    );

    // request capture, free slot, cursor, result and output data (no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= opcode_t'(opcode);
            surf_reg <= surface_id[TAG_W-1:0];
            cell_reg <= cell_id[TAG_W-1:0];
            pay_reg  <= payload;
        end
        if (cmd.scan_chk && !active_reg[idx] && !free_found_reg)
        begin
            free_idx_reg <= idx;
        end
        if (cmd.poll_load)
        begin
            cur_reg <= cur_start;
        end
        else if (cmd.walk_rd)
        begin
            cur_reg <= cur_reg + SEQ_W'(1);
        end
        if (cmd.res_load)
        begin
            res_found_reg <= 1'b0;
            res_seq_reg   <= '0;
            res_surf_reg  <= '0;
            res_pay_reg   <= '0;
            case (cmd.res_sel)
                RES_POST:
                begin
                    res_status_reg <= ST_OK;
                    res_seq_reg    <= wc_reg;
                end
                RES_OK:     res_status_reg <= ST_OK;
                RES_EXISTS: res_status_reg <= ST_EXISTS;
                RES_FULL:   res_status_reg <= ST_FULL;
                RES_HIT:
                begin
                    res_status_reg <= ST_OK;
                    res_found_reg  <= 1'b1;
                    res_seq_reg    <= r_seq;
                    res_surf_reg   <= FIELD_W'(r_surf);
                    res_pay_reg    <= r_pay;
                end
                default:    res_status_reg <= ST_NONE;
            endcase
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
            out_seq_reg    <= res_seq_reg;
            out_surf_reg   <= res_surf_reg;
            out_pay_reg    <= res_pay_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg         <= '0;
            used_reg       <= '0;
            active_reg     <= '0;
            rvalid_reg     <= '0;
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            rv_q_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.post)
            begin
                wc_reg <= wc_reg + SEQ_W'(1);
                rvalid_reg[wc_reg[RING_AW-1:0]] <= 1'b1;
            end
            if (cmd.accept)
            begin
                idx_reg        <= '0;
                free_found_reg <= 1'b0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (cmd.scan_chk && !active_reg[idx])
            begin
                free_found_reg <= 1'b1;
            end
            if (cmd.sub_write)
            begin
                active_reg[pick] <= 1'b1;
                if (!free_found_reg)
                begin
                    used_reg <= used_reg + CNT_W'(1);
                end
            end
            if (cmd.unsub_clear)
            begin
                active_reg[idx] <= 1'b0;
            end
            if (cmd.walk_rd)
            begin
                rv_q_reg <= rvalid_reg[cur_reg[RING_AW-1:0]];
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.op         = op_reg;
        stat.scan_end   = (idx_reg >= used_reg);
        stat.pair_match = active_reg[idx] && (s_surf == surf_reg) && (s_cell == cell_reg);
        stat.cell_hit   = active_reg[idx] && (s_cell == cell_reg);
        stat.free_found = free_found_reg;
        stat.table_full = (used_reg >= CNT_W'(SUB_SLOTS));
        stat.walk_end   = (cur_reg == wc_reg);
        stat.surf_hit   = (r_surf == s_surf);
        stat.out_ready  = !out_valid_reg || !out_stall;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign event_found   = out_found_reg;
    assign event_seq     = out_seq_reg;
    assign event_surface = out_surf_reg;
    assign event_payload = out_pay_reg;

endmodule

// ----- rtl/core/erse_ctrl.sv -----
// ----------------------------------------------------------------------------
// erse_ctrl
// Sequencer for post, subscription scans, cursor walks and result hand-off.
// ----------------------------------------------------------------------------
module erse_ctrl
    import erse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  erse_stat_t stat,
    output erse_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.res_sel = RES_NONE;
        in_stall    = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.op == OP_POST)
                begin
                    cmd.post     = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_POST;
                    state_next   = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (stat.scan_end)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_FINISH;
                    if (stat.op == OP_SUB)
                    begin
                        if (stat.free_found || !stat.table_full)
                        begin
                            cmd.sub_write = 1'b1;
                            cmd.res_sel   = RES_OK;
                        end
                        else
                        begin
                            cmd.res_sel = RES_FULL;
                        end
                    end
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                cmd.scan_chk = 1'b1;
                state_next   = S_SCAN_RD;
                cmd.idx_inc  = 1'b1;
                case (stat.op)
                    OP_SUB:
                    begin
                        if (stat.pair_match)
                        begin
                            cmd.idx_inc  = 1'b0;
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = RES_EXISTS;
                            state_next   = S_FINISH;
                        end
                    end
                    OP_UNSUB:
                    begin
                        if (stat.pair_match)
                        begin
                            cmd.idx_inc     = 1'b0;
                            cmd.unsub_clear = 1'b1;
                            cmd.res_load    = 1'b1;
                            cmd.res_sel     = RES_OK;
                            state_next      = S_FINISH;
                        end
                    end
                    OP_POLL:
                    begin
                        if (stat.cell_hit)
                        begin
                            cmd.idx_inc   = 1'b0;
                            cmd.poll_load = 1'b1;
                            state_next    = S_WALK_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_SCAN_RD;
                    end
                endcase
            end
            S_WALK_RD:
            begin
                if (stat.walk_end)
                begin
                    state_next = S_CUR_WB;
                end
                else
                begin
                    cmd.walk_rd = 1'b1;
                    state_next  = S_WALK_CHK;
                end
            end
            S_WALK_CHK:
            begin
                if (stat.surf_hit)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_HIT;
                    cmd.cur_wb   = 1'b1;
                    state_next   = S_FINISH;
                end
                else
                begin
                    state_next = S_WALK_RD;
                end
            end
            S_CUR_WB:
            begin
                // cursor reached the write count: save it, move to next slot
                cmd.cur_wb  = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = S_SCAN_RD;
            end
            S_FINISH:
            begin
                if (stat.out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/event_ring_subscription_engine_core.sv -----
// ----------------------------------------------------------------------------
// event_ring_subscription_engine_core
// Event fan-out engine: shared event ring plus a table of subscriptions.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid / in_stall): opcode, surface_id, cell_id,
//   payload. A request is taken when in_valid is high and in_stall is low.
//   One request is in work at a time; in_stall is high from acceptance
//   until its result has moved into the output register.
//   Result channel (out_valid / out_stall): status, event_found, event_seq,
//   event_surface, event_payload; one result per request, in order.
//   Work per request, from acceptance to out_valid:
//     post                       ring write at dispatch
//     subscribe / unsubscribe    scan of the slots in use
//     poll                       scan of the slots in use; for each slot of
//                                that cell, a ring walk and a cursor write-back
//     a pair match or a returned event ends the work at that slot
//   The scan reads the subscription RAM slot by slot and the cursor walk
//   reads the ring RAM entry by entry, each read followed by a check.
//   A held result does not block the next request; a finished result waits
//   in the sequencer only while the output register is still stalled.
//   Reset clears write count, slot count, active bits and ring valid bits
//   at once; no clearing pass.
// ----------------------------------------------------------------------------
module event_ring_subscription_engine_core
    import erse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic [FIELD_W-1:0] surface_id,
    input  logic [FIELD_W-1:0] cell_id,
    input  logic [PAY_W-1:0]   payload,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic               event_found,
    output logic [SEQ_W-1:0]   event_seq,
    output logic [FIELD_W-1:0] event_surface,
    output logic [PAY_W-1:0]   event_payload
);

    erse_cmd_t  cmd;
    erse_stat_t stat;

    // sequencer
    erse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // ring, subscription table and output register
    erse_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (opcode),
        .surface_id    (surface_id),
        .cell_id       (cell_id),
        .payload       (payload),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .event_found   (event_found),
        .event_seq     (event_seq),
        .event_surface (event_surface),
        .event_payload (event_payload)
    );

endmodule

// ----- rtl/core/erse_checker.sv -----
// ----------------------------------------------------------------------------
// erse_checker
// Port-level checks of the event ring subscription core.
// ----------------------------------------------------------------------------
module erse_props
    import erse_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         status,
    input logic               event_found,
    input logic [FIELD_W-1:0] event_surface,
    input logic [PAY_W-1:0]   event_payload
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_status_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(status) && $stable(event_found))
        else $error("stalled result changed");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_found |-> status == ST_OK)
        else $error("event returned with non-ok status");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !event_found |-> event_surface == '0 && event_payload == '0)
        else $error("event fields set without an event");

endmodule

bind event_ring_subscription_engine_core erse_props u_erse_props (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .event_found   (event_found),
    .event_surface (event_surface),
    .event_payload (event_payload)
);

// ----- tb/sv/erse_checker.sv -----
// ----------------------------------------------------------------------------
// erse_checker
// Watches both channels of the subscription core, predicts each result and
// compares it field by field with what the core returns.
// ----------------------------------------------------------------------------
module erse_checker
    import erse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic [FIELD_W-1:0] surface_id,
    input  logic [FIELD_W-1:0] cell_id,
    input  logic [PAY_W-1:0]   payload,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [1:0]         status,
    input  logic               event_found,
    input  logic [SEQ_W-1:0]   event_seq,
    input  logic [FIELD_W-1:0] event_surface,
    input  logic [PAY_W-1:0]   event_payload,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        status_t            st;
        logic               found;
        logic [SEQ_W-1:0]   seq;
        logic [FIELD_W-1:0] surf;
        logic [PAY_W-1:0]   pay;
    } outcome_t;

    outcome_t awaited_q[$];

    logic [FIELD_W-1:0] ev_surf [RING_DEPTH];
    logic [PAY_W-1:0]   ev_pay  [RING_DEPTH];
    logic [SEQ_W-1:0]   ev_seq  [RING_DEPTH];
    logic [SEQ_W-1:0]   posts;
    logic [FIELD_W-1:0] sub_surf [SUB_SLOTS];
    logic [FIELD_W-1:0] sub_cell [SUB_SLOTS];
    logic [SEQ_W-1:0]   sub_cur  [SUB_SLOTS];
    logic               sub_on   [SUB_SLOTS];
    int                 slots_used;

    assign pending = awaited_q.size();

    function automatic int find_pair(logic [FIELD_W-1:0] s, logic [FIELD_W-1:0] c);
        for (int i = 0; i < slots_used; i++)
            if (sub_on[i] && sub_surf[i] == s && sub_cell[i] == c)
                return i;
        return -1;
    endfunction

    function automatic outcome_t apply_request(opcode_t op, logic [FIELD_W-1:0] s,
                                               logic [FIELD_W-1:0] c,
                                               logic [PAY_W-1:0] p);
        outcome_t r;
        int hit;
        int pick;
        int slot;
        r = '0;
        r.st = ST_OK;
        case (op)
            OP_POST:
            begin
                slot = posts % RING_DEPTH;
                ev_surf[slot] = s;
                ev_pay[slot] = p;
                ev_seq[slot] = posts;
                r.seq = posts;
                posts = posts + 1;
            end
            OP_SUB:
            begin
                hit = find_pair(s, c);
                pick = -1;
                if (hit >= 0)
                    r.st = ST_EXISTS;
                else
                begin
                    for (int i = 0; i < slots_used; i++)
                        if (!sub_on[i] && pick < 0)
                            pick = i;
                    if (pick < 0 && slots_used >= SUB_SLOTS)
                        r.st = ST_FULL;
                    else
                    begin
                        if (pick < 0)
                        begin
                            pick = slots_used;
                            slots_used++;
                        end
                        sub_surf[pick] = s;
                        sub_cell[pick] = c;
                        sub_cur[pick] = posts;
                        sub_on[pick] = 1'b1;
                    end
                end
            end
            OP_UNSUB:
            begin
                hit = find_pair(s, c);
                if (hit < 0)
                    r.st = ST_NONE;
                else
                    sub_on[hit] = 1'b0;
            end
            default:
            begin
                for (int i = 0; i < slots_used; i++)
                begin
                    if (!sub_on[i] || sub_cell[i] != c)
                        continue;
                    if (SEQ_W'(posts - sub_cur[i]) > RING_DEPTH)
                        sub_cur[i] = posts - RING_DEPTH;
                    while (sub_cur[i] != posts)
                    begin
                        slot = sub_cur[i] % RING_DEPTH;
                        sub_cur[i] = sub_cur[i] + 1;
                        if (ev_surf[slot] == sub_surf[i])
                        begin
                            r.found = 1'b1;
                            r.seq = ev_seq[slot];
                            r.surf = ev_surf[slot];
                            r.pay = ev_pay[slot];
                            return r;
                        end
                    end
                end
                r.st = ST_NONE;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            awaited_q.delete();
            fail_count <= 0;
            posts = '0;
            slots_used = 0;
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ev_surf[i] = '0;
                ev_pay[i] = '0;
                ev_seq[i] = '0;
            end
            for (int i = 0; i < SUB_SLOTS; i++)
                sub_on[i] = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = awaited_q.pop_front();
                    if (status !== want.st || event_found !== want.found ||
                        event_seq !== want.seq || event_surface !== want.surf ||
                        event_payload !== want.pay)
                        fail_count <= fail_count + 1;
                    if (status !== want.st)
                        $error("status exp %0d got %0d", want.st, status);
                    if (event_found !== want.found)
                        $error("event_found exp %0d got %0d", want.found, event_found);
                    if (event_seq !== want.seq)
                        $error("event_seq exp %0h got %0h", want.seq, event_seq);
                    if (event_surface !== want.surf)
                        $error("event_surface exp %0h got %0h", want.surf, event_surface);
                    if (event_payload !== want.pay)
                        $error("event_payload exp %0h got %0h", want.pay, event_payload);
                end
            end
            if (in_valid && !in_stall)
                awaited_q.push_back(apply_request(opcode_t'(opcode), surface_id,
                                                  cell_id, payload));
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives posts, subscribes, unsubscribes and polls into the subscription core
// with bursty requests and a stalling receiver; the checker judges results.
// ----------------------------------------------------------------------------
module tb_top;
    import erse_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         opcode = OP_POST;
    logic [FIELD_W-1:0] surface_id = '0;
    logic [FIELD_W-1:0] cell_id = '0;
    logic [PAY_W-1:0]   payload = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic               event_found;
    logic [SEQ_W-1:0]   event_seq;
    logic [FIELD_W-1:0] event_surface;
    logic [PAY_W-1:0]   event_payload;
    int                 fail_count;
    int                 pending;

    // receiver stall pattern mode, changed by the stimulus between phases
    int                 stall_mode = 0;

    always #5 clk = ~clk;

    event_ring_subscription_engine_core u_top (.*);

    erse_checker u_chk (.*);

    // Receiver: mode 0 never stalls, 1 stalls lightly, 2 heavily,
    // 3 keeps or flips its level at random.
    always @(posedge clk)
    begin
        int run;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default:
            begin
                run = $urandom_range(0, 15);
                out_stall <= (run < 8) ? out_stall : ~out_stall;
            end
        endcase
    end

    // Small tag pools keep subscriptions, polls and posts hitting each other.
    function automatic logic [FIELD_W-1:0] pick_surface();
        return ($urandom_range(0, 19) == 0) ? FIELD_W'($urandom())
                                            : FIELD_W'($urandom_range(0, 5));
    endfunction

    function automatic logic [FIELD_W-1:0] pick_cell();
        return ($urandom_range(0, 19) == 0) ? FIELD_W'($urandom())
                                            : FIELD_W'($urandom_range(0, 3));
    endfunction

    // Hand one request over; in_valid stays high if another follows at once,
    // otherwise it drops.
    task automatic send_request(opcode_t op, logic [FIELD_W-1:0] s,
                                logic [FIELD_W-1:0] c, logic [PAY_W-1:0] p,
                                bit keep_valid);
        in_valid   <= 1'b1;
        opcode     <= op;
        surface_id <= s;
        cell_id    <= c;
        payload    <= p;
        do
            @(posedge clk);
        while (in_stall);
        if (!keep_valid)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int burst;
        int gap;
        int pick;
        logic [PAY_W-1:0] p;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, every op, duplicates, misses, empty poll
        send_request(OP_POLL, '0, '0, '0, 0);
        send_request(OP_UNSUB, 32'd7, 32'd7, '0, 0);
        send_request(OP_SUB, 32'd1, 32'd1, '0, 0);
        send_request(OP_SUB, 32'd1, 32'd1, '0, 0);
        send_request(OP_SUB, '1, '1, '0, 0);
        send_request(OP_SUB, 32'd2, 32'd1, '0, 0);
        send_request(OP_POST, 32'd1, '0, '1, 0);
        send_request(OP_POST, '1, '1, 64'h0123_4567_89ab_cdef, 0);
        send_request(OP_POST, 32'd9, '0, '0, 0);
        send_request(OP_POST, 32'd2, '0, 64'h8000_0000_0000_0001, 0);
        send_request(OP_POLL, '0, 32'd1, '0, 0);
        send_request(OP_POLL, '0, 32'd1, '0, 0);
        send_request(OP_POLL, '0, 32'd1, '0, 0);
        send_request(OP_POLL, '0, '1, '0, 0);
        send_request(OP_POLL, '1, '1, '1, 0);
        send_request(OP_UNSUB, 32'd1, 32'd1, '0, 0);
        send_request(OP_UNSUB, 32'd1, 32'd1, '0, 0);
        send_request(OP_SUB, 32'd3, 32'd1, '0, 0);
        drain();

        // fill the table to report full, then free one slot for reuse
        for (int i = 0; i < SUB_SLOTS + 2; i++)
            send_request(OP_SUB, 32'd100 + i, 32'd50, '0, 1);
        send_request(OP_UNSUB, 32'd110, 32'd50, '0, 1);
        send_request(OP_SUB, 32'd4, 32'd2, '0, 1);
        send_request(OP_SUB, 32'd5, 32'd3, '0, 0);
        drain();
        // clear most of the table so random traffic has room
        for (int i = 0; i < SUB_SLOTS; i++)
            send_request(OP_UNSUB, 32'd100 + i, 32'd50, '0, 1);
        in_valid <= 1'b0;
        drain();

        // lap the ring so lagging cursors jump forward
        for (int i = 0; i < RING_DEPTH + 40; i++)
            send_request(OP_POST, FIELD_W'(i % 6), '0, {$urandom(), $urandom()}, 1);
        send_request(OP_POLL, '0, 32'd1, '0, 1);
        send_request(OP_POLL, '0, 32'd2, '0, 0);

        // random bursts, receiver pattern changes every phase
        for (int phase = 0; phase < 4; phase++)
        begin
            stall_mode = phase;
            for (int n = 0; n < 240;)
            begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst; b++, n++)
                begin
                    pick = $urandom_range(0, 9);
                    p = {$urandom(), $urandom()};
                    if (pick < 4)
                        send_request(OP_POST, pick_surface(), pick_cell(), p,
                                     b != burst - 1);
                    else if (pick < 6)
                        send_request(OP_SUB, pick_surface(), pick_cell(), p,
                                     b != burst - 1);
                    else if (pick < 7)
                        send_request(OP_UNSUB, pick_surface(), pick_cell(), p,
                                     b != burst - 1);
                    else
                        send_request(OP_POLL, pick_surface(), pick_cell(), p,
                                     b != burst - 1);
                end
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                repeat (gap) @(posedge clk);
            end
        end

        stall_mode = 1;
        drain();
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // watchdog: well beyond the slowest legal run
    initial
    begin
        #100000000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
